[sv/lpd_pkg.sv]
// lpd_pkg: shared types and constants of the line position pid drive
// command bundle between sequencer and datapath, register map, field widths
`timescale 1ns / 1ps
`default_nettype none
package lpd_pkg;

	localparam int LINE_SENSORS = 7;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;

	localparam int GAIN_W = 16;
	localparam int SPEED_W = 16;
	localparam int LIMIT_W = 15;
	localparam int TOTAL_W = 13;
	localparam int ERR_W = 11;
	localparam int ACC_W = 24;
	localparam int QUO_W = 10;
	localparam int PROD_W = GAIN_W + 1 + ACC_W + 1;
	localparam int SUM_W = PROD_W + 2;
	localparam int CORR_W = SUM_W - 7;
	localparam int WHEEL_W = CORR_W + 1;
	localparam int ERR_MAX = 768;

	localparam logic [GAIN_W-1:0] GAIN_P_RST = 16'd768;
	localparam logic [GAIN_W-1:0] GAIN_I_RST = 16'd0;
	localparam logic [GAIN_W-1:0] GAIN_D_RST = 16'd717;
	localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 16'd3072;
	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 15'd3840;

	typedef enum logic [2:0] {
		REG_GAIN_P = 3'd0,
		REG_GAIN_I = 3'd1,
		REG_GAIN_D = 3'd2,
		REG_BASE_SPEED = 3'd3,
		REG_SPEED_LIMIT = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_P = 2'd0,
		MUL_I = 2'd1,
		MUL_D = 2'd2
	} mul_sel_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [SPEED_W-1:0] base_speed;
		logic [LIMIT_W-1:0] speed_limit;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic div_step;
		logic err_upd;
		logic mul_en;
		mul_sel_t mul_sel;
		logic sum_ld;
		logic sum_add;
		logic rnd;
		logic out_load;
	} cmd_t;

endpackage
`default_nettype wire

[sv/lpd_datapath.sv]
// lpd_datapath: sensor sums, restoring divider, shared pid multiplier, wheel clamp
// driven by the cmd_t bundle from lpd_ctrl; uses lpd_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpd_datapath #(
	parameter int SAMPLE_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire lpd_pkg::cmd_t cmd,
	input wire lpd_pkg::cfg_t cfg,
	input wire logic [SAMPLE_BITS-1:0] sensor [lpd_pkg::LINE_SENSORS],
	output logic [lpd_pkg::SPEED_W-1:0] left_wheel,
	output logic [lpd_pkg::SPEED_W-1:0] right_wheel,
	output logic [lpd_pkg::TOTAL_W-1:0] sensor_total,
	output logic [lpd_pkg::ERR_W-1:0] line_error
);
	import lpd_pkg::*;

	localparam int TOT_W = SAMPLE_BITS + $clog2(LINE_SENSORS);
	localparam int CENTER = (LINE_SENSORS - 1) / 2;
	localparam int WSUM_W = TOT_W + $clog2(CENTER + 1);
	localparam int NUM_W = WSUM_W + 8;
	localparam int DVS_W = NUM_W + 1;

	function automatic logic [SPEED_W-1:0] clamp_speed(
		input logic signed [WHEEL_W-1:0] v,
		input logic [LIMIT_W-1:0] lim
	);
		logic signed [WHEEL_W-1:0] hi;
		logic signed [WHEEL_W-1:0] lo;
		logic signed [WHEEL_W-1:0] r;
		hi = signed'(WHEEL_W'(lim));
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[SPEED_W-1:0];
	endfunction

	logic signed [WSUM_W-1:0] wsum;
	logic [TOT_W-1:0] tsum;
	logic signed [WSUM_W-1:0] w_q;
	logic [TOT_W-1:0] s_q;
	logic [WSUM_W-1:0] w_mag;
	logic [NUM_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [QUO_W-1:0] quo_q;
	logic neg_q;
	logic zero_q;
	logic ge;
	logic signed [ERR_W-1:0] q_ext;
	logic signed [ERR_W-1:0] err_new;
	logic signed [ACC_W:0] acc_sum;
	logic signed [ACC_W-1:0] acc_sat;
	logic signed [ERR_W:0] deriv;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [ERR_W-1:0] prev_q;
	logic signed [ERR_W-1:0] err_q;
	logic signed [ERR_W:0] der_q;
	logic signed [GAIN_W:0] op_a;
	logic signed [ACC_W:0] op_b;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [SUM_W-1:0] sum_mag;
	logic [SUM_W-1:0] sum_rnd;
	logic signed [CORR_W-1:0] corr_mag;
	logic signed [CORR_W-1:0] corr_q;
	logic signed [WHEEL_W-1:0] base_w;
	logic signed [WHEEL_W-1:0] left_raw;
	logic signed [WHEEL_W-1:0] right_raw;
	logic [TOT_W+TOTAL_W-1:0] tot_wide;

	// weighted and plain sums of the readings
	always_comb begin
		wsum = '0;
		tsum = '0;
		for (int i = 0; i < LINE_SENSORS; i++) begin
			wsum = wsum + WSUM_W'(signed'({1'b0, sensor[i]})) * WSUM_W'(i - CENTER);
			tsum = tsum + TOT_W'(sensor[i]);
		end
	end

	assign w_mag = w_q[WSUM_W-1] ? WSUM_W'(-w_q) : WSUM_W'(w_q);
	assign ge = {1'b0, rem_q} >= dvs_q;

	assign q_ext = signed'(ERR_W'(quo_q));
	assign err_new = zero_q ? '0 : (neg_q ? -q_ext : q_ext);
	assign acc_sum = (ACC_W+1)'(acc_q) + (ACC_W+1)'(err_new);
	assign acc_sat = (acc_sum[ACC_W] != acc_sum[ACC_W-1]) ?
		(acc_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}}) :
		acc_sum[ACC_W-1:0];
	assign deriv = (ERR_W+1)'(err_new) - (ERR_W+1)'(prev_q);

	always_comb begin
		case (cmd.mul_sel)
			MUL_P: begin
				op_a = signed'({1'b0, cfg.gain_p});
				op_b = (ACC_W+1)'(err_q);
			end
			MUL_I: begin
				op_a = signed'({1'b0, cfg.gain_i});
				op_b = (ACC_W+1)'(acc_q);
			end
			MUL_D: begin
				op_a = signed'({1'b0, cfg.gain_d});
				op_b = (ACC_W+1)'(der_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// q.16 correction back to q.8, half away from zero
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign sum_rnd = sum_mag + SUM_W'(128);
	assign corr_mag = signed'({1'b0, sum_rnd[SUM_W-1:8]});

	assign base_w = WHEEL_W'($signed(cfg.base_speed));
	assign left_raw = base_w - WHEEL_W'(corr_q);
	assign right_raw = base_w + WHEEL_W'(corr_q);
	assign tot_wide = (TOT_W+TOTAL_W)'(s_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			prev_q <= '0;
		end else if (cmd.err_upd) begin
			acc_q <= acc_sat;
			prev_q <= err_new;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q <= wsum;
			s_q <= tsum;
		end
		if (cmd.prep) begin
			rem_q <= NUM_W'({w_mag, 8'b0}) + NUM_W'(s_q >> 1);
			dvs_q <= DVS_W'(s_q) << (QUO_W - 1);
			quo_q <= '0;
			neg_q <= w_q[WSUM_W-1];
			zero_q <= (s_q == '0);
		end
		if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q[NUM_W-1:0];
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
		if (cmd.err_upd) begin
			err_q <= err_new;
			der_q <= deriv;
		end
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
		if (cmd.sum_ld) begin
			sum_q <= SUM_W'(prod_q);
		end else if (cmd.sum_add) begin
			sum_q <= sum_q + SUM_W'(prod_q);
		end
		if (cmd.rnd) begin
			corr_q <= sum_q[SUM_W-1] ? -corr_mag : corr_mag;
		end
		if (cmd.out_load) begin
			left_wheel <= clamp_speed(left_raw, cfg.speed_limit);
			right_wheel <= clamp_speed(right_raw, cfg.speed_limit);
			sensor_total <= tot_wide[TOTAL_W-1:0];
			line_error <= err_q;
		end
	end

endmodule
`default_nettype wire

[sv/lpd_ctrl.sv]
// lpd_ctrl: sequencer for one request and the result valid flag
// issues the cmd_t bundle to lpd_datapath; uses lpd_pkg
`timescale 1ns / 1ps
`default_nettype none
module lpd_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic sensor_valid,
	output logic sensor_stall,
	output logic drive_valid,
	input wire logic drive_stall,
	output lpd_pkg::cmd_t cmd
);
	import lpd_pkg::*;

	localparam int CNT_W = $clog2(QUO_W);

	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_PREP = 10'b00_0000_0010,
		ST_DIV = 10'b00_0000_0100,
		ST_ERR = 10'b00_0000_1000,
		ST_MULP = 10'b00_0001_0000,
		ST_MULI = 10'b00_0010_0000,
		ST_MULD = 10'b00_0100_0000,
		ST_ACC = 10'b00_1000_0000,
		ST_RND = 10'b01_0000_0000,
		ST_WHL = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic [CNT_W-1:0] cnt_q;
	logic valid_q;
	logic out_free;

	assign out_free = !valid_q || !drive_stall;
	assign sensor_stall = (state_q != ST_IDLE);
	assign drive_valid = valid_q;

	always_comb begin
		cmd = '0;
		cmd.mul_sel = MUL_P;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sensor_valid) begin
					cmd.load = 1'b1;
					state_nxt = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(QUO_W - 1)) begin
					state_nxt = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.err_upd = 1'b1;
				state_nxt = ST_MULP;
			end
			ST_MULP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_P;
				state_nxt = ST_MULI;
			end
			ST_MULI: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_I;
				cmd.sum_ld = 1'b1;
				state_nxt = ST_MULD;
			end
			ST_MULD: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = MUL_D;
				cmd.sum_add = 1'b1;
				state_nxt = ST_ACC;
			end
			ST_ACC: begin
				cmd.sum_add = 1'b1;
				state_nxt = ST_RND;
			end
			ST_RND: begin
				cmd.rnd = 1'b1;
				state_nxt = ST_WHL;
			end
			ST_WHL: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				cnt_q <= '0;
			end
			if (cmd.out_load) begin
				valid_q <= 1'b1;
			end else if (valid_q && !drive_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[sv/line_position_pid_drive.sv]
// line_position_pid_drive: a request is accepted in the idle state; its result is
// loaded into the result register after the 10-step restoring divider and the three
// passes through the shared multiplier, and the next request is taken only when the
// sequencer is back in idle after that load. the result register frees the
// sequencer while a result waits. arst_n clears the sequencer, integral, last error
// and loads the register reset values
`timescale 1ns / 1ps
`default_nettype none
module line_position_pid_drive #(
	parameter int SAMPLE_BITS = 10
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [lpd_pkg::ADDR_W-1:0] paddr,
	input wire logic [lpd_pkg::DATA_W-1:0] pwdata,
	output logic [lpd_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input wire logic sensor_valid,
	output logic sensor_stall,
	input wire logic [SAMPLE_BITS-1:0] sensor_a,
	input wire logic [SAMPLE_BITS-1:0] sensor_b,
	input wire logic [SAMPLE_BITS-1:0] sensor_c,
	input wire logic [SAMPLE_BITS-1:0] sensor_d,
	input wire logic [SAMPLE_BITS-1:0] sensor_e,
	input wire logic [SAMPLE_BITS-1:0] sensor_f,
	input wire logic [SAMPLE_BITS-1:0] sensor_g,
	output logic drive_valid,
	input wire logic drive_stall,
	output logic signed [lpd_pkg::SPEED_W-1:0] left_wheel,
	output logic signed [lpd_pkg::SPEED_W-1:0] right_wheel,
	output logic [lpd_pkg::TOTAL_W-1:0] sensor_total,
	output logic signed [lpd_pkg::ERR_W-1:0] line_error
);
	import lpd_pkg::*;

	cfg_t cfg_q;
	cmd_t cmd;
	reg_idx_t reg_idx;
	logic [SAMPLE_BITS-1:0] sensor_arr [LINE_SENSORS];
	logic signed [LIMIT_W+1:0] lim_s;

	assign sensor_arr[0] = sensor_a;
	assign sensor_arr[1] = sensor_b;
	assign sensor_arr[2] = sensor_c;
	assign sensor_arr[3] = sensor_d;
	assign sensor_arr[4] = sensor_e;
	assign sensor_arr[5] = sensor_f;
	assign sensor_arr[6] = sensor_g;

	// register file
	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p <= GAIN_P_RST;
			cfg_q.gain_i <= GAIN_I_RST;
			cfg_q.gain_d <= GAIN_D_RST;
			cfg_q.base_speed <= BASE_SPEED_RST;
			cfg_q.speed_limit <= SPEED_LIMIT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx)
				REG_GAIN_P: cfg_q.gain_p <= pwdata[GAIN_W-1:0];
				REG_GAIN_I: cfg_q.gain_i <= pwdata[GAIN_W-1:0];
				REG_GAIN_D: cfg_q.gain_d <= pwdata[GAIN_W-1:0];
				REG_BASE_SPEED: cfg_q.base_speed <= pwdata[SPEED_W-1:0];
				REG_SPEED_LIMIT: cfg_q.speed_limit <= pwdata[LIMIT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_GAIN_P: prdata = DATA_W'(cfg_q.gain_p);
			REG_GAIN_I: prdata = DATA_W'(cfg_q.gain_i);
			REG_GAIN_D: prdata = DATA_W'(cfg_q.gain_d);
			REG_BASE_SPEED: prdata = DATA_W'(cfg_q.base_speed);
			REG_SPEED_LIMIT: prdata = DATA_W'(cfg_q.speed_limit);
			default: prdata = '0;
		endcase
	end

	lpd_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sensor_valid(sensor_valid),
		.sensor_stall(sensor_stall),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.cmd(cmd)
	);

	lpd_datapath #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.cfg(cfg_q),
		.sensor(sensor_arr),
		.left_wheel(left_wheel),
		.right_wheel(right_wheel),
		.sensor_total(sensor_total),
		.line_error(line_error)
	);

	assign lim_s = signed'({2'b00, cfg_q.speed_limit});

	a_busy_after_request: assert property (@(posedge clk) disable iff (!arst_n)
		(sensor_valid && !sensor_stall) |=> sensor_stall)
		else $error("request accepted while a request is in flight");

	a_left_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> (left_wheel <= lim_s) && (left_wheel >= -lim_s))
		else $error("left wheel outside limit");

	a_error_range: assert property (@(posedge clk) disable iff (!arst_n)
		drive_valid |-> (line_error <= ERR_W'(ERR_MAX)) && (line_error >= -ERR_W'(ERR_MAX)))
		else $error("line error outside range");

endmodule
`default_nettype wire

[verif/line_position_pid_drive_tb.sv]
// line_position_pid_drive_tb: self-checking bench for the line position pid drive
// drives sensor requests and apb register writes, predicts each wheel result in-bench
// depends on lpd_pkg and line_position_pid_drive
`timescale 1ns / 1ps
module line_position_pid_drive_tb;
	import lpd_pkg::*;

	localparam int SAMPLE_BITS = 10;
	localparam int REG_COUNT = 5;
	localparam longint ACC_HI = (longint'(1) << (ACC_W - 1)) - 1;
	localparam longint ACC_LO = -(longint'(1) << (ACC_W - 1));
	localparam int HOLD_CYCLES = 400;

	typedef logic [LINE_SENSORS-1:0][SAMPLE_BITS-1:0] sensor_set_t;

	typedef struct packed {
		logic signed [SPEED_W-1:0] left;
		logic signed [SPEED_W-1:0] right;
		logic [TOTAL_W-1:0] total;
		logic signed [ERR_W-1:0] err;
	} drive_t;

	logic clk;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic sensor_valid = 1'b0;
	logic sensor_stall;
	logic [SAMPLE_BITS-1:0] sensor_a = '0;
	logic [SAMPLE_BITS-1:0] sensor_b = '0;
	logic [SAMPLE_BITS-1:0] sensor_c = '0;
	logic [SAMPLE_BITS-1:0] sensor_d = '0;
	logic [SAMPLE_BITS-1:0] sensor_e = '0;
	logic [SAMPLE_BITS-1:0] sensor_f = '0;
	logic [SAMPLE_BITS-1:0] sensor_g = '0;
	logic drive_valid;
	logic drive_stall = 1'b0;
	logic signed [SPEED_W-1:0] left_wheel;
	logic signed [SPEED_W-1:0] right_wheel;
	logic [TOTAL_W-1:0] sensor_total;
	logic signed [ERR_W-1:0] line_error;

	line_position_pid_drive #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.sensor_valid(sensor_valid),
		.sensor_stall(sensor_stall),
		.sensor_a(sensor_a),
		.sensor_b(sensor_b),
		.sensor_c(sensor_c),
		.sensor_d(sensor_d),
		.sensor_e(sensor_e),
		.sensor_f(sensor_f),
		.sensor_g(sensor_g),
		.drive_valid(drive_valid),
		.drive_stall(drive_stall),
		.left_wheel(left_wheel),
		.right_wheel(right_wheel),
		.sensor_total(sensor_total),
		.line_error(line_error)
	);

	// bench copy of the register file and pid state
	longint kp = longint'(GAIN_P_RST);
	longint ki = longint'(GAIN_I_RST);
	longint kd = longint'(GAIN_D_RST);
	longint base_spd = longint'(signed'(BASE_SPEED_RST));
	longint spd_lim = longint'(SPEED_LIMIT_RST);
	longint integ = 0;
	longint prev_pos = 0;

	drive_t pending_drive[$];
	int errors = 0;

	bit stall_on = 1'b0;
	bit pressure_req = 1'b0;
	int hold_cnt = 0;
	int burst_cnt = 0;
	bit stall_level = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	function automatic longint round_div(input longint num, input longint den);
		longint mag;
		longint q;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic drive_t predict_drive(input sensor_set_t s);
		drive_t r;
		longint wsum;
		longint total;
		longint err;
		longint deriv;
		longint corr;
		longint lft;
		longint rgt;
		wsum = 0;
		total = 0;
		err = 0;
		for (int i = 0; i < LINE_SENSORS; i++) begin
			wsum += (i - (LINE_SENSORS - 1) / 2) * longint'({1'b0, s[i]});
			total += longint'({1'b0, s[i]});
		end
		if (total != 0)
			err = round_div(wsum * 256, total);
		integ = clamp_to(integ + err, ACC_LO, ACC_HI);
		deriv = err - prev_pos;
		prev_pos = err;
		corr = round_div(kp * err + ki * integ + kd * deriv, 256);
		lft = clamp_to(base_spd - corr, -spd_lim, spd_lim);
		rgt = clamp_to(base_spd + corr, -spd_lim, spd_lim);
		r.left = lft[SPEED_W-1:0];
		r.right = rgt[SPEED_W-1:0];
		r.total = total[TOTAL_W-1:0];
		r.err = err[ERR_W-1:0];
		return r;
	endfunction

	function automatic void cfg_apply(input int idx, input logic [DATA_W-1:0] d);
		case (idx)
			REG_GAIN_P: kp = longint'(d[GAIN_W-1:0]);
			REG_GAIN_I: ki = longint'(d[GAIN_W-1:0]);
			REG_GAIN_D: kd = longint'(d[GAIN_W-1:0]);
			REG_BASE_SPEED: base_spd = longint'(signed'(d[SPEED_W-1:0]));
			REG_SPEED_LIMIT: spd_lim = longint'(d[LIMIT_W-1:0]);
			default: ;
		endcase
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 80)
			return $urandom_range(1, 3);
		if (p < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic sensor_set_t random_sensors();
		sensor_set_t s;
		int p;
		int k;
		p = $urandom_range(0, 99);
		s = '0;
		if (p < 50) begin
			for (int i = 0; i < LINE_SENSORS; i++)
				s[i] = SAMPLE_BITS'($urandom);
		end else if (p < 75) begin
			// a line under one or two neighboring sensors, small noise elsewhere
			k = $urandom_range(0, LINE_SENSORS - 2);
			for (int i = 0; i < LINE_SENSORS; i++)
				s[i] = SAMPLE_BITS'($urandom_range(0, 40));
			s[k] = SAMPLE_BITS'($urandom_range(300, 1023));
			s[k+1] = SAMPLE_BITS'($urandom_range(0, 1023));
		end else if (p < 90) begin
			for (int i = 0; i < LINE_SENSORS; i++)
				s[i] = SAMPLE_BITS'($urandom_range(0, 2));
		end else if (p < 95) begin
			s = '0;
		end else begin
			s = '1;
		end
		return s;
	endfunction

	function automatic logic [DATA_W-1:0] reg_value(input logic [15:0] lo_v,
			input logic [15:0] hi_v);
		logic [DATA_W-1:0] r;
		r = $urandom;
		case ($urandom_range(0, 9))
			0, 1: r[15:0] = lo_v;
			2, 3: r[15:0] = hi_v;
			4, 5: r[15:0] = 16'($urandom_range(0, 1023));
			default: ;
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			errors++;
			if (errors <= 40)
				$display("%0t %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	// drive result checker
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && drive_valid && !drive_stall) begin
			if (pending_drive.size() == 0) begin
				errors++;
				if (errors <= 40)
					$display("%0t unexpected result expected none actual %0d %0d %0d %0d",
						$time, left_wheel, right_wheel, sensor_total, line_error);
			end else begin
				want = pending_drive.pop_front();
				check_field("left_wheel", longint'(want.left), longint'(left_wheel));
				check_field("right_wheel", longint'(want.right), longint'(right_wheel));
				check_field("sensor_total", longint'(want.total), longint'(sensor_total));
				check_field("line_error", longint'(want.err), longint'(line_error));
			end
		end
	end

	// receiver stall generator, with a long hold on request
	always @(posedge clk) begin
		if (pressure_req) begin
			hold_cnt = HOLD_CYCLES;
			pressure_req = 1'b0;
		end
		if (burst_cnt == 0) begin
			stall_level = ($urandom_range(0, 2) == 0);
			burst_cnt = gap_len();
		end
		burst_cnt--;
		drive_stall <= (hold_cnt > 0) || (stall_on && stall_level);
		if (hold_cnt > 0)
			hold_cnt--;
	end

	task automatic reg_write(input int idx, input logic [DATA_W-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cfg_apply(idx, data);
		@(posedge clk);
	endtask

	task automatic send_sensors(input sensor_set_t s, input bit may_idle);
		int gap;
		sensor_valid <= 1'b1;
		sensor_a <= s[0];
		sensor_b <= s[1];
		sensor_c <= s[2];
		sensor_d <= s[3];
		sensor_e <= s[4];
		sensor_f <= s[5];
		sensor_g <= s[6];
		do @(posedge clk); while (sensor_stall);
		pending_drive.push_back(predict_drive(s));
		if (may_idle && $urandom_range(0, 1)) begin
			gap = gap_len();
			sensor_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		sensor_valid <= 1'b0;
		while (pending_drive.size() != 0)
			@(posedge clk);
		repeat (24) @(posedge clk);
	endtask

	task automatic write_all(input logic [DATA_W-1:0] gp, input logic [DATA_W-1:0] gi,
			input logic [DATA_W-1:0] gd, input logic [DATA_W-1:0] bs,
			input logic [DATA_W-1:0] lim);
		reg_write(REG_GAIN_P, gp);
		reg_write(REG_GAIN_I, gi);
		reg_write(REG_GAIN_D, gd);
		reg_write(REG_BASE_SPEED, bs);
		reg_write(REG_SPEED_LIMIT, lim);
	endtask

	task automatic test_directed();
		sensor_set_t s;
		stall_on = 1'b1;
		send_sensors('0, 1'b1);
		send_sensors('1, 1'b1);
		s = '0; s[0] = '1;
		send_sensors(s, 1'b1);
		s = '0; s[6] = '1;
		send_sensors(s, 1'b1);
		// zero sum right after a hard error still feeds integral and derivative
		send_sensors('0, 1'b1);
		s = '0; s[3] = '1;
		send_sensors(s, 1'b1);
		// position ties, away from zero both ways
		s = '0; s[0] = 1; s[3] = 511;
		send_sensors(s, 1'b1);
		s = '0; s[6] = 1; s[3] = 511;
		send_sensors(s, 1'b1);
		s = '0; s[1] = 1;
		send_sensors(s, 1'b1);
		for (int i = 0; i < LINE_SENSORS; i++)
			s[i] = (i % 2) ? SAMPLE_BITS'(10'h2AA) : SAMPLE_BITS'(10'h155);
		send_sensors(s, 1'b1);
		for (int i = 0; i < LINE_SENSORS; i++)
			s[i] = (i % 2) ? SAMPLE_BITS'(10'h155) : SAMPLE_BITS'(10'h2AA);
		send_sensors(s, 1'b1);
		s = '0; s[5] = 1023; s[4] = 1;
		send_sensors(s, 1'b1);
		drain();
	endtask

	task automatic test_config_extremes();
		sensor_set_t s;
		for (int k = 0; k < 3; k++) begin
			case (k)
				0: write_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
					32'hA5A5_7FFF, 32'hFFFF_7FFF);
				1: write_all(32'h1234_0000, 32'h0, 32'hFFFF_0000,
					32'h0000_8000, 32'h0001_8000);
				default: write_all(32'h0000_0100, 32'h0000_FFFF, 32'h0,
					32'h0, 32'h0000_7FFF);
			endcase
			// unknown register indexes must not disturb anything
			for (int u = REG_COUNT; u < 8; u++)
				reg_write(u, $urandom);
			s = '0; s[0] = '1;
			send_sensors(s, 1'b1);
			s = '0; s[6] = '1;
			send_sensors(s, 1'b1);
			send_sensors('0, 1'b1);
			send_sensors(random_sensors(), 1'b1);
			drain();
		end
	endtask

	task automatic test_integral_ramp();
		sensor_set_t hi_s;
		sensor_set_t lo_s;
		hi_s = '0; hi_s[6] = '1;
		lo_s = '0; lo_s[0] = '1;
		stall_on = 1'b0;
		// integral only, base at the bottom so the accumulated value shows unclamped
		write_all(32'h0, 32'h1, 32'h0, 32'h0000_8000, 32'h0000_7FFF);
		for (int n = 0; n < 300; n++)
			send_sensors(hi_s, 1'b0);
		for (int n = 0; n < 300; n++)
			send_sensors(lo_s, 1'b0);
		drain();
	endtask

	task automatic test_backpressure();
		stall_on = 1'b1;
		pressure_req = 1'b1;
		for (int n = 0; n < 40; n++)
			send_sensors(random_sensors(), 1'b0);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			write_all(reg_value(16'h0000, 16'hFFFF), reg_value(16'h0000, 16'hFFFF),
				reg_value(16'h0000, 16'hFFFF), reg_value(16'h8000, 16'h7FFF),
				reg_value(16'h0000, 16'h7FFF));
			reg_write($urandom_range(REG_COUNT, 7), $urandom);
			stall_on = (ph != 0);
			for (int n = 0; n < 200; n++)
				send_sensors(random_sensors(), ph != 0);
			drain();
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_config_extremes();
		test_integral_ramp();
		test_backpressure();
		test_random();
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

[sim.f]
sv/lpd_pkg.sv
sv/lpd_datapath.sv
sv/lpd_ctrl.sv
sv/line_position_pid_drive.sv
verif/line_position_pid_drive_tb.sv
